/* rtl/soft_knee_lookahead_compressor_top_macros.svh */
`ifndef SOFT_KNEE_LOOKAHEAD_COMPRESSOR_TOP_MACROS_SVH
`define SOFT_KNEE_LOOKAHEAD_COMPRESSOR_TOP_MACROS_SVH
// same-cycle implication, held off while in reset
`define SKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("skc check failed");
// next-cycle implication, held off while in reset
`define SKC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("skc check failed");
`endif

/* rtl/skc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package skc_pkg;
	localparam int SAMPLE_BITS     = 24;
	localparam int LOOKAHEAD_DEPTH = 2048;
	localparam int ADDR_W          = $clog2(LOOKAHEAD_DEPTH);
	localparam int DB_W            = 20;
	localparam int Q16_ONE         = 65536;
	localparam int LOG_SCALE       = 394566;
	localparam int P_W             = $clog2(SAMPLE_BITS);
	localparam int DIV_N_W         = (SAMPLE_BITS + 16 > 35) ? SAMPLE_BITS + 16 : 35;
	localparam int DIV_D_W         = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_W           = 17;
	localparam int LA_W            = 11;

	localparam logic [SAMPLE_BITS-1:0] UNITY = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_DB  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RATIO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_COEF     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FALL_COEF     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE_AMOUNT   = 3'd5;

	typedef struct packed {
		logic                   start;
		logic [SAMPLE_BITS-1:0] value;
	} lvl_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [DB_W-1:0] db;
	} lvl_rsp_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] num;
		logic [DIV_D_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DIV_N_W-1:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

/* rtl/skc_delay.sv */
`timescale 1ns / 1ps
`default_nettype none
module skc_delay import skc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   wr_en,
	input  wire logic [ADDR_W-1:0]      wr_addr,
	input  wire logic [SAMPLE_BITS-1:0] wr_data,
	input  wire logic                   rd_en,
	input  wire logic [ADDR_W-1:0]      rd_addr,
	output logic      [SAMPLE_BITS-1:0] rd_data,
	output logic                        ready
);
	logic [SAMPLE_BITS-1:0] mem [LOOKAHEAD_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic [ADDR_W-1:0]      clr_q;
	logic                   clearing_q;

	// zero sweep after reset, one word a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == ADDR_W'(LOOKAHEAD_DEPTH - 1))
				clearing_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_q] <= '0;
		else if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign ready   = !clearing_q;
endmodule
`default_nettype wire

/* rtl/skc_level.sv */
`timescale 1ns / 1ps
`default_nettype none
module skc_level import skc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire lvl_req_t req,
	output lvl_rsp_t      rsp
);
	localparam int LG_W = P_W + 17;

	typedef enum logic [1:0] {L_IDLE, L_SQ, L_MUL, L_OUT} lstate_t;

	lstate_t                  state_q;
	logic [30:0]              m_q;
	logic [P_W-1:0]           p_q;
	logic [15:0]              frac_q;
	logic [3:0]               cnt_q;
	logic signed [LG_W+19:0]  prod_q;
	logic                     done_q;
	logic signed [DB_W-1:0]   db_q;

	logic [SAMPLE_BITS-1:0]   v1;
	logic [P_W-1:0]           p_w;
	logic [63:0]              v64;
	logic [30:0]              m_w;
	logic [61:0]              sq;
	logic [31:0]              sq30;
	logic signed [P_W:0]      pm;
	logic signed [LG_W-1:0]   lg;
	logic signed [LG_W+19:0]  biased;

	always_comb begin
		v1 = (req.value == '0) ? SAMPLE_BITS'(1) : req.value;
		p_w = '0;
		for (int i = 0; i < SAMPLE_BITS; i++) begin
			if (v1[i])
				p_w = P_W'(i);
		end
		v64 = 64'(v1);
		if (int'(p_w) <= 30)
			m_w = 31'(v64 << (30 - int'(p_w)));
		else
			m_w = 31'(v64 >> (int'(p_w) - 30));
		sq   = 62'(m_q) * 62'(m_q);
		sq30 = sq[61:30];
		pm   = $signed({1'b0, p_q}) - $signed((P_W + 1)'(SAMPLE_BITS - 1));
		lg   = $signed({pm, frac_q});
		// truncate toward zero on the scale down
		biased = prod_q[LG_W+19] ? prod_q + (LG_W + 20)'(24'hFF_FFFF) : prod_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= (state_q == L_OUT);
			unique case (state_q)
				L_IDLE: begin
					if (req.start) begin
						m_q     <= m_w;
						p_q     <= p_w;
						frac_q  <= '0;
						cnt_q   <= '0;
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					// one squaring a cycle, one fraction bit of log2 each
					if (sq30[31]) begin
						m_q    <= sq30[31:1];
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						m_q    <= sq30[30:0];
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd15)
						state_q <= L_MUL;
				end
				L_MUL: begin
					prod_q  <= lg * $signed(20'(LOG_SCALE));
					state_q <= L_OUT;
				end
				L_OUT: begin
					db_q    <= DB_W'(biased >>> 24);
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.db   = db_q;
endmodule
`default_nettype wire

/* rtl/skc_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module skc_div import skc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_D_W:0]   rem_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_D_W:0]   trial;
	logic               fits;

	always_comb begin
		trial = {rem_q[DIV_D_W-1:0], quo_q[DIV_N_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DIV_N_W - 1));
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
					rem_q  <= '0;
					quo_q  <= req.num;
					den_q  <= req.den;
				end
			end else begin
				rem_q <= fits ? trial - {1'b0, den_q} : trial;
				quo_q <= {quo_q[DIV_N_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_N_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule
`default_nettype wire

/* rtl/soft_knee_lookahead_compressor_top.sv */
// Soft-knee look-ahead compressor: one signed Q1.23 word in, one word out, one item at a
// time. After reset the 2048-word look-ahead memory is swept to zero, and in_ready stays
// low during the sweep (configuration writes are taken throughout). Most of the work on an
// item goes to up to three binary searches for the threshold, knee-floor and gain
// amplitudes, each probe being one pass of the shared log unit (sixteen squarings), plus
// two divisions inside the knee. A finished word waits in the output register while the
// next word is taken in.
`timescale 1ns / 1ps
`default_nettype none
`include "soft_knee_lookahead_compressor_top_macros.svh"
module soft_knee_lookahead_compressor_top import skc_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	input  wire logic                          cfg_write,
	input  wire logic [CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_data
);
	typedef enum logic [4:0] {
		ST_IDLE, ST_FOL1, ST_FOL2, ST_LVL_REQ, ST_LVL_WAIT, ST_SRCH_NEXT, ST_SRCH_DONE,
		ST_DECIDE, ST_DIV1, ST_DIV1_W, ST_CURVE, ST_DIV2, ST_DIV2_W, ST_SLOPE,
		ST_ENV_REQ, ST_ENV_WAIT, ST_OUTDB1, ST_OUTDB2, ST_MUL, ST_OUT
	} state_t;

	typedef enum logic [1:0] {PH_TH, PH_KF, PH_GAIN} phase_t;
	typedef enum logic [1:0] {SS_HI, SS_LO, SS_MID} sstep_t;

	localparam int SB = SAMPLE_BITS;

	// configuration
	logic signed [15:0] thr_q;
	logic [16:0]        ir_q;
	logic [15:0]        rise_q;
	logic [15:0]        fall_q;
	logic [LA_W-1:0]    la_q;
	logic [16:0]        knee_q;

	state_t                 state_q;
	phase_t                 phase_q;
	sstep_t                 sstep_q;
	logic [ADDR_W-1:0]      wpos_q;
	logic [SB-1:0]          env_q;
	logic [SB-1:0]          a_q;
	logic [15:0]            c_q;
	logic [SB+16:0]         fol_p_q;
	logic signed [SB-1:0]   samp_q;
	logic signed [DB_W-1:0] target_q;
	logic [SB-1:0]          lo_q;
	logic [SB-1:0]          hi_q;
	logic [SB-1:0]          mid_q;
	logic [SB-1:0]          res_q;
	logic [SB-1:0]          amp_th_q;
	logic [SB-1:0]          amp_kf_q;
	logic [SB-1:0]          gain_q;
	logic [16:0]            s_q;
	logic [34:0]            cnum_q;
	logic [16:0]            curve_q;
	logic [16:0]            mult_q;
	logic signed [DB_W-1:0] diff_q;
	logic signed [DB_W+17:0] od_p_q;
	logic signed [2*SB:0]   fin_p_q;
	logic                   out_valid_q;
	logic signed [SB-1:0]   out_sample_q;

	logic                   mem_ready;
	logic [SB-1:0]          rd_data;
	logic                   accept;
	logic [SB-1:0]          a_w;
	logic [ADDR_W-1:0]      d_w;
	logic [16:0]            knee_c;
	logic [16:0]            ir_c;
	logic [16:0]            one_m_ir;
	logic [16:0]            one_m_c;
	logic [18:0]            t3;
	logic [28:0]            tkf;
	logic [33:0]            tk;
	logic [17:0]            k_w;
	logic signed [DB_W-1:0] th_raw;
	logic signed [DB_W-1:0] th_w;
	logic signed [DB_W-1:0] kf_w;
	logic [SB+15:0]         cenv;
	logic [SB+17:0]         fol_sum;
	logic [33:0]            slope;
	logic signed [DB_W+17:0] od_b;
	logic signed [DB_W-1:0] outdb;
	logic signed [2*SB:0]   fin_b;
	logic                   le;
	lvl_req_t               lvl_req;
	lvl_rsp_t               lvl_rsp;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= -16'sd5120;
			ir_q   <= 17'd32768;
			rise_q <= 16'd65387;
			fall_q <= 16'd65521;
			la_q   <= '0;
			knee_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_THRESHOLD_DB:  thr_q  <= cfg_data[15:0];
				REG_INVERSE_RATIO: ir_q   <= cfg_data;
				REG_RISE_COEF:     rise_q <= cfg_data[15:0];
				REG_FALL_COEF:     fall_q <= cfg_data[15:0];
				REG_LOOKAHEAD:     la_q   <= cfg_data[LA_W-1:0];
				REG_KNEE_AMOUNT:   knee_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		accept   = in_valid && in_ready;
		a_w      = in_sample[SB-1] ? SB'(-in_sample) : SB'(in_sample);
		d_w      = (32'(la_q) > LOOKAHEAD_DEPTH - 1) ? ADDR_W'(LOOKAHEAD_DEPTH - 1)
			: ADDR_W'(la_q);
		knee_c   = (knee_q > 17'(Q16_ONE)) ? 17'(Q16_ONE) : knee_q;
		ir_c     = (ir_q > 17'(Q16_ONE)) ? 17'(Q16_ONE) : ir_q;
		one_m_ir = 17'(Q16_ONE) - ir_c;
		one_m_c  = 17'(Q16_ONE) - 17'(c_q);
		t3       = 19'(knee_c) * 19'd3 + 19'd128;
		tkf      = 29'(knee_c) * 29'd2176 + 29'd32768;
		tk       = 34'(knee_c) * 34'd65470 + 34'd32768;
		k_w      = 18'(tk[33:16]) + 18'd66;
		// effective threshold moves up with the knee, never above 0 dB
		th_raw   = DB_W'(thr_q) + $signed(DB_W'(t3[18:8]));
		th_w     = th_raw[DB_W-1] ? th_raw : '0;
		kf_w     = th_w - $signed(DB_W'(tkf[28:16])) - $signed(DB_W'(128));
		cenv     = c_q * env_q;
		fol_sum  = (SB + 18)'(fol_p_q) + (SB + 18)'(cenv) + (SB + 18)'(32768);
		slope    = curve_q * one_m_ir;
		od_b     = od_p_q[DB_W+17] ? od_p_q + (DB_W + 18)'(16'hFFFF) : od_p_q;
		outdb    = DB_W'(od_b >>> 16);
		fin_b    = fin_p_q[2*SB] ? fin_p_q + (2 * SB + 1)'(UNITY - 1'b1) : fin_p_q;
		le       = lvl_rsp.db <= target_q;
	end

	assign in_ready = (state_q == ST_IDLE) && mem_ready;

	always_comb begin
		lvl_req.start = (state_q == ST_LVL_REQ) || (state_q == ST_ENV_REQ);
		if (state_q == ST_ENV_REQ)
			lvl_req.value = env_q;
		else if (sstep_q == SS_HI)
			lvl_req.value = hi_q;
		else if (sstep_q == SS_LO)
			lvl_req.value = lo_q;
		else
			lvl_req.value = mid_q;
		div_req.start = (state_q == ST_DIV1) || (state_q == ST_DIV2);
		if (state_q == ST_DIV1) begin
			div_req.num = DIV_N_W'({env_q - amp_kf_q, 16'h0000});
			div_req.den = DIV_D_W'(amp_th_q - amp_kf_q);
		end else begin
			div_req.num = DIV_N_W'(cnum_q);
			div_req.den = DIV_D_W'(k_w + 18'(s_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_TH;
			sstep_q     <= SS_HI;
			wpos_q      <= '0;
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT))
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						a_q     <= a_w;
						c_q     <= (env_q < a_w) ? rise_q : fall_q;
						state_q <= ST_FOL1;
					end
				end
				ST_FOL1: begin
					fol_p_q <= a_q * one_m_c;
					wpos_q  <= wpos_q + 1'b1;
					state_q <= ST_FOL2;
				end
				ST_FOL2: begin
					env_q    <= fol_sum[SB+15:16];
					samp_q   <= rd_data;
					phase_q  <= PH_TH;
					target_q <= th_w;
					lo_q     <= SB'(1);
					hi_q     <= UNITY;
					sstep_q  <= SS_HI;
					state_q  <= ST_LVL_REQ;
				end
				ST_LVL_REQ: state_q <= ST_LVL_WAIT;
				ST_LVL_WAIT: begin
					if (lvl_rsp.done) begin
						unique case (sstep_q)
							SS_HI: begin
								if (le) begin
									res_q   <= hi_q;
									state_q <= ST_SRCH_DONE;
								end else begin
									sstep_q <= SS_LO;
									state_q <= ST_LVL_REQ;
								end
							end
							SS_LO: begin
								if (!le) begin
									res_q   <= lo_q;
									state_q <= ST_SRCH_DONE;
								end else begin
									state_q <= ST_SRCH_NEXT;
								end
							end
							default: begin
								if (le)
									lo_q <= mid_q;
								else
									hi_q <= mid_q;
								state_q <= ST_SRCH_NEXT;
							end
						endcase
					end
				end
				ST_SRCH_NEXT: begin
					if (hi_q - lo_q > SB'(1)) begin
						mid_q   <= lo_q + ((hi_q - lo_q) >> 1);
						sstep_q <= SS_MID;
						state_q <= ST_LVL_REQ;
					end else begin
						res_q   <= lo_q;
						state_q <= ST_SRCH_DONE;
					end
				end
				ST_SRCH_DONE: begin
					unique case (phase_q)
						PH_TH: begin
							amp_th_q <= res_q;
							phase_q  <= PH_KF;
							target_q <= kf_w;
							lo_q     <= SB'(1);
							hi_q     <= UNITY;
							sstep_q  <= SS_HI;
							state_q  <= ST_LVL_REQ;
						end
						PH_KF: begin
							amp_kf_q <= res_q;
							state_q  <= ST_DECIDE;
						end
						default: begin
							gain_q  <= res_q;
							state_q <= ST_MUL;
						end
					endcase
				end
				ST_DECIDE: begin
					if (env_q > amp_th_q) begin
						mult_q  <= one_m_ir;
						state_q <= ST_ENV_REQ;
					end else if (env_q > amp_kf_q) begin
						state_q <= ST_DIV1;
					end else begin
						gain_q  <= UNITY;
						state_q <= ST_MUL;
					end
				end
				ST_DIV1: state_q <= ST_DIV1_W;
				ST_DIV1_W: begin
					if (div_rsp.done) begin
						s_q     <= div_rsp.quo[16:0];
						state_q <= ST_CURVE;
					end
				end
				ST_CURVE: begin
					cnum_q  <= (k_w + 18'(Q16_ONE)) * s_q;
					state_q <= ST_DIV2;
				end
				ST_DIV2: state_q <= ST_DIV2_W;
				ST_DIV2_W: begin
					if (div_rsp.done) begin
						curve_q <= div_rsp.quo[16:0];
						state_q <= ST_SLOPE;
					end
				end
				ST_SLOPE: begin
					mult_q  <= slope[32:16];
					state_q <= ST_ENV_REQ;
				end
				ST_ENV_REQ: state_q <= ST_ENV_WAIT;
				ST_ENV_WAIT: begin
					if (lvl_rsp.done) begin
						diff_q  <= lvl_rsp.db - th_w;
						state_q <= ST_OUTDB1;
					end
				end
				ST_OUTDB1: begin
					od_p_q  <= diff_q * $signed({1'b0, mult_q});
					state_q <= ST_OUTDB2;
				end
				ST_OUTDB2: begin
					phase_q  <= PH_GAIN;
					target_q <= -outdb;
					lo_q     <= SB'(1);
					hi_q     <= UNITY;
					sstep_q  <= SS_HI;
					state_q  <= ST_LVL_REQ;
				end
				ST_MUL: begin
					fin_p_q <= samp_q * $signed({1'b0, gain_q});
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_sample_q <= SB'(fin_b >>> (SB - 1));
						out_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	skc_delay u_delay (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_addr (wpos_q),
		.wr_data (in_sample),
		.rd_en   (state_q == ST_FOL1),
		.rd_addr (wpos_q - d_w),
		.rd_data (rd_data),
		.ready   (mem_ready)
	);

	skc_level u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lvl_req),
		.rsp    (lvl_rsp)
	);

	skc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	`SKC_ASSERT_IMP(a_no_word_while_clearing, clk, arst_n, in_ready, mem_ready)
	`SKC_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, accept, state_q != ST_IDLE)
	`SKC_ASSERT_IMP(a_knee_floor_below_th, clk, arst_n, state_q == ST_DECIDE, amp_th_q >= amp_kf_q)
	`SKC_ASSERT_NEXT(a_write_pos_steps, clk, arst_n, state_q == ST_FOL1, wpos_q == $past(wpos_q) + 1'b1)
endmodule
`default_nettype wire

/* tb/tb_soft_knee_lookahead_compressor_top.sv */
`timescale 1ns / 1ps
module tb_soft_knee_lookahead_compressor_top;
	import skc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam longint CYCLE_LIMIT = 40_000_000;
	localparam int N_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 135;

	class compressor_scoreboard;
		logic [15:0] thr_db;
		logic [16:0] inv_ratio;
		logic [15:0] rise_pole;
		logic [15:0] fall_pole;
		logic [10:0] delay_len;
		logic [16:0] knee_amt;
		longint envelope;
		logic [SAMPLE_BITS-1:0] delay_line [LOOKAHEAD_DEPTH];
		int wr_pos;
		logic [SAMPLE_BITS-1:0] expected_words[$];
		int errors;

		function new();
			thr_db = 16'hEC00;
			inv_ratio = 17'd32768;
			rise_pole = 16'd65387;
			fall_pole = 16'd65521;
			delay_len = '0;
			knee_amt = '0;
			envelope = 0;
			wr_pos = 0;
			errors = 0;
			foreach (delay_line[i]) delay_line[i] = '0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				REG_THRESHOLD_DB:  thr_db = val[15:0];
				REG_INVERSE_RATIO: inv_ratio = val;
				REG_RISE_COEF:     rise_pole = val[15:0];
				REG_FALL_COEF:     fall_pole = val[15:0];
				REG_LOOKAHEAD:     delay_len = val[10:0];
				REG_KNEE_AMOUNT:   knee_amt = val;
				default: ;
			endcase
		endfunction

		// level in dB, Q8.8, via log2 by repeated squaring
		function longint level_db(longint v);
			longint t, m, p, lg;
			longint frac;
			p = 0;
			frac = 0;
			if (v == 0) v = 1;
			t = v;
			while (t > 1) begin
				t = t >> 1;
				p++;
			end
			if (p <= 30) m = v << (30 - p);
			else m = v >> (p - 30);
			for (int i = 0; i < 16; i++) begin
				m = (m * m) >> 30;
				frac = frac << 1;
				if (m >= (longint'(2) << 30)) begin
					m = m >> 1;
					frac = frac | 1;
				end
			end
			lg = (p - (SAMPLE_BITS - 1)) * 65536 + frac;
			return (lg * 394566) / 16777216;
		endfunction

		// largest amplitude whose level stays at or below the target
		function longint amp_for_db(longint target);
			longint lo, hi, mid;
			lo = 1;
			hi = longint'(1) << (SAMPLE_BITS - 1);
			if (level_db(hi) <= target) return hi;
			if (level_db(lo) > target) return lo;
			while (hi - lo > 1) begin
				mid = lo + ((hi - lo) >> 1);
				if (level_db(mid) <= target) lo = mid;
				else hi = mid;
			end
			return lo;
		endfunction

		function void take_sample(logic [SAMPLE_BITS-1:0] word);
			longint x, a, c, th, kf, amp_th, amp_kf, gain, knee, ir, samp, diff, outdb;
			longint s, k, curve, m, prod;
			int rd_pos, d;
			x = longint'($signed(word));
			a = (x < 0) ? -x : x;
			knee = (knee_amt > 17'd65536) ? 65536 : longint'(knee_amt);
			ir = (inv_ratio > 17'd65536) ? 65536 : longint'(inv_ratio);
			gain = longint'(1) << (SAMPLE_BITS - 1);

			c = (envelope < a) ? longint'(rise_pole) : longint'(fall_pole);
			envelope = (a * (65536 - c) + c * envelope + 32768) >> 16;

			// written before the read so a zero delay passes straight through
			delay_line[wr_pos] = word;
			d = int'(delay_len);
			if (d > LOOKAHEAD_DEPTH - 1) d = LOOKAHEAD_DEPTH - 1;
			rd_pos = (wr_pos + LOOKAHEAD_DEPTH - d) % LOOKAHEAD_DEPTH;
			samp = longint'($signed(delay_line[rd_pos]));
			wr_pos = (wr_pos + 1) % LOOKAHEAD_DEPTH;

			th = longint'($signed(thr_db)) + ((3 * knee + 128) >> 8);
			if (th > 0) th = 0;
			kf = th - ((knee * 2176 + 32768) >> 16) - 128;
			amp_th = amp_for_db(th);
			amp_kf = amp_for_db(kf);

			if (envelope > amp_th) begin
				diff = level_db(envelope) - th;
				outdb = diff * (65536 - ir) / 65536;
				gain = amp_for_db(-outdb);
			end else if (envelope > amp_kf) begin
				s = ((envelope - amp_kf) << 16) / (amp_th - amp_kf);
				k = ((knee * 65470 + 32768) >> 16) + 66;
				curve = ((k + 65536) * s) / (k + s);
				m = (curve * (65536 - ir)) >> 16;
				diff = level_db(envelope) - th;
				outdb = diff * m / 65536;
				gain = amp_for_db(-outdb);
			end
			prod = (samp * gain) / (longint'(1) << (SAMPLE_BITS - 1));
			expected_words.push_back(prod[SAMPLE_BITS-1:0]);
		endfunction

		task report_mismatch(string what, logic [SAMPLE_BITS-1:0] got,
				logic [SAMPLE_BITS-1:0] want);
			$display("mismatch %s: out_sample got %0d want %0d", what,
				$signed(got), $signed(want));
			errors++;
		endtask

		task check_word(logic [SAMPLE_BITS-1:0] got);
			logic [SAMPLE_BITS-1:0] want;
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", got, '0);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) report_mismatch("value", got, want);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic out_valid;
	logic out_ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	compressor_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	longint cycles;
	int burst_left;
	int burst_kind;

	soft_knee_lookahead_compressor_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_sample(in_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_sample(out_sample),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver side: check on the sampled handshake, then choose the next ready
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && out_valid && out_ready) sb.check_word(out_sample);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic send_word(logic [SAMPLE_BITS-1:0] word);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_sample <= word;
		do @(posedge clk); while (!in_ready);
		sb.take_sample(word);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// bursts of similar loudness so the follower climbs into the knee and past it
	function automatic logic [SAMPLE_BITS-1:0] audio_word();
		int mag;
		logic [SAMPLE_BITS-1:0] w;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 5);
			burst_kind = $urandom_range(9);
		end
		burst_left--;
		case (burst_kind)
			0, 1, 2, 3: mag = $urandom_range(8388607, 1 << 20);
			4, 5, 6: mag = $urandom_range(1 << 20, 1 << 14);
			7, 8: mag = $urandom_range(1 << 14, 0);
			default: mag = -1;
		endcase
		if (mag < 0) w = SAMPLE_BITS'($urandom);
		else if ($urandom_range(1)) w = SAMPLE_BITS'(-mag);
		else w = SAMPLE_BITS'(mag);
		return w;
	endfunction

	initial begin
		logic [SAMPLE_BITS-1:0] directed [20];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_sample = '0;
		out_ready = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_THRESHOLD_DB;
		cfg_data = '0;
		cycles = 0;
		burst_left = 0;
		burst_kind = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// extremes, zero level, and runs of full scale to drive the level up
		directed = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
			24'h555555, 24'hAAAAAA, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
			24'h7FFFFF, 24'h800000, 24'h400000, 24'hC00000, 24'h100000,
			24'h000000, 24'h000000, 24'h7FFFFF, 24'h000010, 24'hFFFFF0};
		foreach (directed[i]) send_word(directed[i]);

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			case (p)
				0: begin
					write_reg(REG_THRESHOLD_DB, 17'h1FFFF & -17'sd1280);
					write_reg(REG_KNEE_AMOUNT, 17'd65536);
					write_reg(REG_LOOKAHEAD, 17'd3);
				end
				1: begin
					write_reg(REG_THRESHOLD_DB, 17'd0);
					write_reg(REG_INVERSE_RATIO, 17'd0);
					write_reg(REG_RISE_COEF, 17'd0);
					write_reg(REG_FALL_COEF, 17'd0);
					write_reg(REG_LOOKAHEAD, 17'd0);
					write_reg(REG_KNEE_AMOUNT, 17'd0);
				end
				2: begin
					write_reg(REG_THRESHOLD_DB, 17'h1FFFF & -17'sd30720);
					write_reg(REG_INVERSE_RATIO, 17'd65536);
					write_reg(REG_RISE_COEF, 17'd65535);
					write_reg(REG_FALL_COEF, 17'd65535);
					write_reg(REG_LOOKAHEAD, 17'd2047);
					write_reg(REG_KNEE_AMOUNT, 17'd65536);
				end
				3: begin
					// out-of-range ratio and knee saturate, spare indexes are ignored
					write_reg(REG_INVERSE_RATIO, 17'h1FFFF);
					write_reg(REG_KNEE_AMOUNT, 17'h1FFFF);
					write_reg(REG_RISE_COEF, 17'd40000);
					write_reg(REG_FALL_COEF, 17'd65000);
					write_reg(REG_THRESHOLD_DB, 17'h1FFFF & -17'sd7000);
					write_reg(REG_SPARE_LO, 17'($urandom));
					write_reg(REG_SPARE_HI, 17'($urandom));
				end
				default: begin
					write_reg(REG_THRESHOLD_DB,
						17'(-$urandom_range(30720, 0)));
					write_reg(REG_INVERSE_RATIO, 17'($urandom_range(65536, 0)));
					write_reg(REG_RISE_COEF, 17'($urandom_range(65535, 0)));
					write_reg(REG_FALL_COEF, 17'($urandom_range(65535, 30000)));
					write_reg(REG_LOOKAHEAD, 17'($urandom_range(1) ?
						$urandom_range(40, 0) : $urandom_range(2047, 0)));
					write_reg(REG_KNEE_AMOUNT, 17'($urandom_range(65536, 0)));
				end
			endcase
			cfg_write <= 1'b0;
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 53; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 53; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == 2 && i == ITEMS_PER_PHASE / 2) drain();
				send_word(audio_word());
			end
		end

		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/skc_pkg.sv
rtl/skc_delay.sv
rtl/skc_level.sv
rtl/skc_div.sv
rtl/soft_knee_lookahead_compressor_top.sv
tb/tb_soft_knee_lookahead_compressor_top.sv
